// ===== design/sqs_pkg.sv =====
// ----------------------------------------------------------------------------
// sqs_pkg
// Shared widths, codes and control types for the shifting queue with search.
// ----------------------------------------------------------------------------
`default_nettype none

package sqs_pkg;

  localparam int DATA_W = 32;
  localparam int OP_W   = 3;
  localparam int ST_W   = 2;
  localparam int POS_W  = 4;
  localparam int CNT_W  = 5;

  localparam logic [CNT_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic [OP_W-1:0] {
    OP_ENQ    = 3'd0,
    OP_DEQ    = 3'd1,
    OP_PEEK   = 3'd2,
    OP_CLEAR  = 3'd3,
    OP_SEARCH = 3'd4
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;   // latch request
    logic idx_clr;   // scan index back to front
    logic idx_inc;   // step scan index
    logic finish;    // commit update, load result register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_search;  // request on the input is a search
    logic out_free;   // result register can take a result this cycle
    logic scan_done;  // scan hit or ran past the last entry
  } sts_t;

endpackage

`default_nettype wire

// ===== design/sqs_req_if.sv =====
// ----------------------------------------------------------------------------
// sqs_req_if
// Request channel: valid/ready handshake with opcode and value.
// ----------------------------------------------------------------------------
`default_nettype none

interface sqs_req_if;
  logic                             valid;
  logic                             ready;
  logic [sqs_pkg::OP_W-1:0]         opcode;
  logic signed [sqs_pkg::DATA_W-1:0] value;

  modport source (output valid, output opcode, output value, input ready);
  modport sink   (input valid, input opcode, input value, output ready);
endinterface

`default_nettype wire

// ===== design/sqs_rsp_if.sv =====
// ----------------------------------------------------------------------------
// sqs_rsp_if
// Result channel: valid/ready handshake with status, data and queue flags.
// ----------------------------------------------------------------------------
`default_nettype none

interface sqs_rsp_if;
  logic                              valid;
  logic                              ready;
  logic [sqs_pkg::ST_W-1:0]          status;
  logic signed [sqs_pkg::DATA_W-1:0] data_out;
  logic [sqs_pkg::POS_W-1:0]         found_position;
  logic [sqs_pkg::CNT_W-1:0]         count;
  logic                              is_empty;
  logic                              is_full;

  modport source (output valid, output status, output data_out, output found_position,
                  output count, output is_empty, output is_full, input ready);
  modport sink   (input valid, input status, input data_out, input found_position,
                  input count, input is_empty, input is_full, output ready);
endinterface

`default_nettype wire

// ===== design/sqs_ctrl.sv =====
// ----------------------------------------------------------------------------
// sqs_ctrl
// Sequencer: takes a request, runs the scan for searches, commits the result.
// ----------------------------------------------------------------------------
`default_nettype none

module sqs_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire sqs_pkg::sts_t sts,
  output sqs_pkg::cmd_t      cmd
);

  sqs_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sqs_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    case (state)
      sqs_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          cmd.idx_clr = 1'b1;
          state_next  = sts.is_search ? sqs_pkg::S_SCAN : sqs_pkg::S_EXEC;
        end
      end
      sqs_pkg::S_EXEC: begin
        // front word already read; wait for a free result register
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_next = sqs_pkg::S_IDLE;
        end
      end
      sqs_pkg::S_SCAN: begin
        if (sts.scan_done) begin
          if (sts.out_free) begin
            cmd.finish = 1'b1;
            state_next = sqs_pkg::S_IDLE;
          end
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      default: begin
        state_next = sqs_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== design/sqs_dp.sv =====
// ----------------------------------------------------------------------------
// sqs_dp
// Datapath: circular entry store, head and count, scan compare, result reg.
// ----------------------------------------------------------------------------
`default_nettype none

module sqs_dp #(
  parameter int DEPTH = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // configuration
  input  wire logic                          cfg_wr_en,
  input  wire logic [sqs_pkg::CNT_W-1:0]     cfg_wr_data,
  // request payload
  input  wire logic [sqs_pkg::OP_W-1:0]      in_opcode,
  input  wire logic [sqs_pkg::DATA_W-1:0]    in_value,
  // result channel
  input  wire logic                          out_ready,
  output logic                               out_valid,
  output logic [sqs_pkg::ST_W-1:0]           out_status,
  output logic [sqs_pkg::DATA_W-1:0]         out_data,
  output logic [sqs_pkg::POS_W-1:0]          out_pos,
  output logic [sqs_pkg::CNT_W-1:0]          out_count,
  output logic                               out_empty,
  output logic                               out_full,
  // control
  input  wire sqs_pkg::cmd_t                 cmd,
  output sqs_pkg::sts_t                      sts
);

  localparam int CW      = sqs_pkg::CNT_W;
  localparam int DW      = sqs_pkg::DATA_W;
  localparam int AW      = $clog2(DEPTH);
  localparam int SW      = ((AW > CW) ? AW : CW) + 1;
  localparam int CAP_MAX = (DEPTH < 31) ? DEPTH : 31;
  localparam logic [CW-1:0] CAP_MAX_C = CW'(CAP_MAX);

  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                             input logic [CW-1:0] off);
    logic [SW-1:0] s;
    s = SW'(base) + SW'(off);
    if (s >= SW'(DEPTH)) s = s - SW'(DEPTH);
    return s[AW-1:0];
  endfunction

  logic [DW-1:0]          mem [DEPTH];
  logic [DW-1:0]          rdata;
  logic [CW-1:0]          capacity;
  logic [AW-1:0]          head, head_next;
  logic [CW-1:0]          count, count_next;
  logic [sqs_pkg::OP_W-1:0] op_q;
  logic [DW-1:0]          key_q;
  logic [CW-1:0]          idx;
  logic [CW-1:0]          rd_off;
  logic [AW-1:0]          rd_addr;
  logic [AW-1:0]          tail;
  logic [CW-1:0]          cap_eff;
  logic                   full_now;
  logic                   hit;
  logic                   do_write;
  logic [sqs_pkg::ST_W-1:0] res_status;
  logic [DW-1:0]          res_data;
  logic [sqs_pkg::POS_W-1:0] res_pos;

  assign cap_eff  = (capacity == '0) ? CW'(1)
                  : ((capacity > CAP_MAX_C) ? CAP_MAX_C : capacity);
  assign full_now = (count >= cap_eff);
  assign tail     = wrap_add(head, count);
  assign rd_off   = cmd.idx_clr ? '0 : (cmd.idx_inc ? idx + CW'(1) : idx);
  assign rd_addr  = wrap_add(head, rd_off);
  assign hit      = (idx < count) && (rdata == key_q);

  assign sts.is_search = (in_opcode == sqs_pkg::OP_SEARCH);
  assign sts.out_free  = !out_valid || out_ready;
  assign sts.scan_done = (idx >= count) || hit;

  // store
  always_ff @(posedge clk) begin
    if (do_write) begin
      mem[tail] <= key_q;
    end
    rdata <= mem[rd_addr];
  end

  always_comb begin
    head_next  = head;
    count_next = count;
    do_write   = 1'b0;
    res_status = sqs_pkg::ST_OK;
    res_data   = '0;
    res_pos    = '0;
    case (op_q)
      sqs_pkg::OP_ENQ: begin
        if (full_now) begin
          res_status = sqs_pkg::ST_FULL;
        end else begin
          do_write   = cmd.finish;
          count_next = count + CW'(1);
        end
      end
      sqs_pkg::OP_DEQ: begin
        if (count == '0) begin
          res_status = sqs_pkg::ST_EMPTY;
        end else begin
          res_data   = rdata;
          head_next  = wrap_add(head, CW'(1));
          count_next = count - CW'(1);
        end
      end
      sqs_pkg::OP_PEEK: begin
        if (count == '0) begin
          res_status = sqs_pkg::ST_EMPTY;
        end else begin
          res_data = rdata;
        end
      end
      sqs_pkg::OP_CLEAR: begin
        count_next = '0;
      end
      sqs_pkg::OP_SEARCH: begin
        if (hit) begin
          res_pos = idx[sqs_pkg::POS_W-1:0];
        end else begin
          res_status = sqs_pkg::ST_NOTFOUND;
        end
      end
      default: begin
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity  <= sqs_pkg::CAP_RESET;
      head      <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        capacity <= cfg_wr_data;
      end
      if (cmd.finish) begin
        head      <= head_next;
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q  <= in_opcode;
      key_q <= in_value;
    end
    if (cmd.idx_clr) begin
      idx <= '0;
    end else if (cmd.idx_inc) begin
      idx <= idx + CW'(1);
    end
    if (cmd.finish) begin
      out_status <= res_status;
      out_data   <= res_data;
      out_pos    <= res_pos;
      out_count  <= count_next;
      out_empty  <= (count_next == '0);
      out_full   <= (count_next >= cap_eff);
    end
  end

endmodule

`default_nettype wire

// ===== design/shifting_queue_with_search.sv =====
// ----------------------------------------------------------------------------
// shifting_queue_with_search
// FIFO of signed 32-bit words with enqueue, dequeue, peek, clear and search.
// ----------------------------------------------------------------------------
// Usage
//   req : request channel (opcode, value), valid/ready; a transfer happens
//         when both are high at a rising edge.
//   rsp : one result per request (status, data_out, found_position, count,
//         is_empty, is_full), valid/ready, held in an output register.
//   cfg_wr_en / cfg_wr_data : capacity write, taken at any edge with the
//         enable high; write only while the block is idle. Zero acts as one,
//         values above DEPTH act as DEPTH.
// Timing
//   Entries sit in a circular store with one registered read port; dequeue
//   moves the head pointer rather than the data.
//   Enqueue, dequeue, peek, clear: the request is captured and the front word
//   read, then the result is committed; a new request is taken only after that commit.
//   Search: one entry read a cycle from the front; the scan ends on the first
//   match (position = its offset from the front) or past the last entry on a miss.
// Reset
//   rst (synchronous) empties the queue, drops any pending result and sets
//   capacity to 16. Stored words are not cleared.
// Stall
//   A result waits in the output register while rsp.ready is low; the next
//   request is still taken and runs up to its commit, where it waits.
// ----------------------------------------------------------------------------
`default_nettype none

module shifting_queue_with_search #(
  parameter int DEPTH = 16
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  sqs_req_if.sink                        req,
  sqs_rsp_if.source                      rsp,
  input  wire logic                      cfg_wr_en,
  input  wire logic [sqs_pkg::CNT_W-1:0] cfg_wr_data
);

  sqs_pkg::cmd_t cmd;
  sqs_pkg::sts_t sts;

  logic [sqs_pkg::DATA_W-1:0] out_data;

  // sequencer: one request at a time
  sqs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // store, pointers, compare and result register
  sqs_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_opcode   (req.opcode),
    .in_value    (req.value),
    .out_ready   (rsp.ready),
    .out_valid   (rsp.valid),
    .out_status  (rsp.status),
    .out_data    (out_data),
    .out_pos     (rsp.found_position),
    .out_count   (rsp.count),
    .out_empty   (rsp.is_empty),
    .out_full    (rsp.is_full),
    .cmd         (cmd),
    .sts         (sts)
  );

  assign rsp.data_out = signed'(out_data);

endmodule

`default_nettype wire
